// ----- sv/irnec_pkg.sv -----
// ----------------------------------------------------------------------------
// irnec_pkg
// Shared types, constants and helpers for the NEC infrared edge decoder.
// ----------------------------------------------------------------------------
package irnec_pkg;

   localparam int unsigned EDGE_LIMIT       = 128;
   localparam int unsigned FULL_FRAME_EDGES = 66;
   localparam int unsigned REPEAT_MIN_EDGES = 2;
   localparam int unsigned REPEAT_MAX_EDGES = 4;
   localparam int unsigned DATA_BITS        = 32;
   localparam int unsigned TIME_W           = 16;
   localparam int unsigned COUNT_W          = 8;
   localparam int unsigned BITS_W           = 6;
   localparam int unsigned CSR_INDEX_W      = 3;
   localparam int unsigned QUEUE_DEPTH      = 2;
   localparam int unsigned QPTR_W           = 1;
   localparam int unsigned QCOUNT_W         = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEADER_LOW_MIN  = 3'd0,
      CSR_LEADER_LOW_MAX  = 3'd1,
      CSR_LEADER_HIGH_MIN = 3'd2,
      CSR_LEADER_HIGH_MAX = 3'd3,
      CSR_FRAME_END_MIN   = 3'd4,
      CSR_ONE_BIT_MIN     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [TIME_W-1:0] leader_low_min;
      logic [TIME_W-1:0] leader_low_max;
      logic [TIME_W-1:0] leader_high_min;
      logic [TIME_W-1:0] leader_high_max;
      logic [TIME_W-1:0] frame_end_min;
      logic [TIME_W-1:0] one_bit_min;
   } csr_type;

   // classified edge handed from front to back
   typedef struct packed {
      logic rising;
      logic leader_low_ok;
      logic leader_high_ok;
      logic frame_end;
      logic one_bit;
   } edge_type;

   typedef struct packed {
      logic              status;
      logic              is_repeat;
      logic              raw_flag;
      logic [TIME_W-1:0] address_out;
      logic [TIME_W-1:0] command_out;
   } result_type;

   function automatic logic inverted_pair(input logic [15:0] w);
      return w[15:8] == ~w[7:0];
   endfunction

endpackage

// ----- sv/ir_nec_edge_decoder_top.sv -----
// ----------------------------------------------------------------------------
// ir_nec_edge_decoder_top
// NEC infrared remote decoder fed with timestamped line edges.
// ----------------------------------------------------------------------------
// Each request is one line edge with its 16 bit timer stamp. The block takes
// one edge per clock unless the queue is full: the front measures and
// classifies the interval in the cycle the request is accepted, a two entry
// queue hands it to the back, which updates the frame state and loads the
// result register when a falling edge with a long interval closes the frame.
// Requests stall only when the queue is full, which happens only while a
// result is held by rsp_stall. The user must write thresholds through the
// csr_ port only while no frame is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module ir_nec_edge_decoder_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_rising_edge,
   input  logic [irnec_pkg::TIME_W-1:0]       req_edge_time,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_status,
   output logic                               rsp_is_repeat,
   output logic                               rsp_raw_flag,
   output logic [irnec_pkg::TIME_W-1:0]       rsp_address_out,
   output logic [irnec_pkg::TIME_W-1:0]       rsp_command_out,
   input  logic                               csr_write_enable,
   input  logic [irnec_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [irnec_pkg::TIME_W-1:0]       csr_write_data
);

   irnec_pkg::csr_type    csr;
   irnec_pkg::edge_type   push_edge;
   irnec_pkg::edge_type   pop_edge;
   irnec_pkg::result_type rsp;
   logic                  push;
   logic                  pop;
   logic                  pop_valid;
   logic                  queue_full;

   irnec_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .csr              (csr)
   );

   irnec_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rising_edge (req_rising_edge),
      .req_edge_time   (req_edge_time),
      .csr             (csr),
      .queue_full      (queue_full),
      .push            (push),
      .push_edge       (push_edge)
   );

   irnec_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_edge (push_edge),
      .pop       (pop),
      .pop_valid (pop_valid),
      .pop_edge  (pop_edge),
      .full      (queue_full)
   );

   irnec_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_edge  (pop_edge),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   assign rsp_status      = rsp.status;
   assign rsp_is_repeat   = rsp.is_repeat;
   assign rsp_raw_flag    = rsp.raw_flag;
   assign rsp_address_out = rsp.address_out;
   assign rsp_command_out = rsp.command_out;

endmodule

// ----- sv/irnec_csr.sv -----
// ----------------------------------------------------------------------------
// irnec_csr
// Timing threshold registers with a plain indexed write port.
// ----------------------------------------------------------------------------
module irnec_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [irnec_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [irnec_pkg::TIME_W-1:0]         csr_write_data,
   output irnec_pkg::csr_type                   csr
);

   irnec_pkg::csr_type csr_ff;
   irnec_pkg::csr_type csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         unique case (irnec_pkg::csr_index_type'(csr_index))
            irnec_pkg::CSR_LEADER_LOW_MIN:  csr_in.leader_low_min  = csr_write_data;
            irnec_pkg::CSR_LEADER_LOW_MAX:  csr_in.leader_low_max  = csr_write_data;
            irnec_pkg::CSR_LEADER_HIGH_MIN: csr_in.leader_high_min = csr_write_data;
            irnec_pkg::CSR_LEADER_HIGH_MAX: csr_in.leader_high_max = csr_write_data;
            irnec_pkg::CSR_FRAME_END_MIN:   csr_in.frame_end_min   = csr_write_data;
            irnec_pkg::CSR_ONE_BIT_MIN:     csr_in.one_bit_min     = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.leader_low_min  <= 16'd8000;
         csr_ff.leader_low_max  <= 16'd10000;
         csr_ff.leader_high_min <= 16'd2000;
         csr_ff.leader_high_max <= 16'd5000;
         csr_ff.frame_end_min   <= 16'd10000;
         csr_ff.one_bit_min     <= 16'd1000;
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

// ----- sv/irnec_front.sv -----
// ----------------------------------------------------------------------------
// irnec_front
// Accepts edge requests, measures the interval since the previous edge and
// classifies it against the thresholds.
// ----------------------------------------------------------------------------
module irnec_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_rising_edge,
   input  logic [irnec_pkg::TIME_W-1:0]  req_edge_time,
   input  irnec_pkg::csr_type            csr,
   input  logic                          queue_full,
   output logic                          push,
   output irnec_pkg::edge_type           push_edge
);

   logic [irnec_pkg::TIME_W-1:0] prev_time_ff;
   logic [irnec_pkg::TIME_W-1:0] prev_time_in;
   logic [irnec_pkg::TIME_W-1:0] dur;

   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // wrap formula: (0xFFFF - prev) + t when the timer went past zero
   always_comb begin
      if (req_edge_time >= prev_time_ff) begin
         dur = req_edge_time - prev_time_ff;
      end else begin
         dur = (16'hFFFF - prev_time_ff) + req_edge_time;
      end
      push_edge.rising         = req_rising_edge;
      push_edge.leader_low_ok  = (dur >= csr.leader_low_min) && (dur <= csr.leader_low_max);
      push_edge.leader_high_ok = (dur >= csr.leader_high_min) && (dur <= csr.leader_high_max);
      push_edge.frame_end      = dur >= csr.frame_end_min;
      push_edge.one_bit        = dur > csr.one_bit_min;
      prev_time_in             = push ? req_edge_time : prev_time_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_time_ff <= '0;
      end else begin
         prev_time_ff <= prev_time_in;
      end
   end

endmodule

// ----- sv/irnec_queue.sv -----
// ----------------------------------------------------------------------------
// irnec_queue
// Small register queue of classified edges between front and back.
// ----------------------------------------------------------------------------
module irnec_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  irnec_pkg::edge_type  push_edge,
   input  logic                 pop,
   output logic                 pop_valid,
   output irnec_pkg::edge_type  pop_edge,
   output logic                 full
);

   irnec_pkg::edge_type                 entry_ff [irnec_pkg::QUEUE_DEPTH];
   logic [irnec_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [irnec_pkg::QPTR_W-1:0]        wr_ptr_in;
   logic [irnec_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [irnec_pkg::QPTR_W-1:0]        rd_ptr_in;
   logic [irnec_pkg::QCOUNT_W-1:0]      count_ff;
   logic [irnec_pkg::QCOUNT_W-1:0]      count_in;
   logic                                do_pop;

   assign pop_valid = count_ff != '0;
   assign full      = count_ff == irnec_pkg::QCOUNT_W'(irnec_pkg::QUEUE_DEPTH);
   assign pop_edge  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_edge;
      end
   end

endmodule

// ----- sv/irnec_back.sv -----
// ----------------------------------------------------------------------------
// irnec_back
// Frame tracking, on the fly bit decode, frame end checks and the result
// register.
// ----------------------------------------------------------------------------
module irnec_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 pop_valid,
   input  irnec_pkg::edge_type  pop_edge,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output irnec_pkg::result_type rsp
);

   logic                               receiving_ff, receiving_in;
   logic [irnec_pkg::COUNT_W-1:0]      edge_count_ff, edge_count_in;
   logic                               leader_high_ok_ff, leader_high_ok_in;
   logic                               pair_first_rising_ff, pair_first_rising_in;
   logic [irnec_pkg::BITS_W-1:0]       bits_done_ff, bits_done_in;
   logic [15:0]                        address_shift_ff, address_shift_in;
   logic [15:0]                        command_shift_ff, command_shift_in;
   logic [15:0]                        saved_address_ff, saved_address_in;
   logic [15:0]                        saved_command_ff, saved_command_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   irnec_pkg::result_type              rsp_ff, rsp_in;

   logic [irnec_pkg::COUNT_W-1:0]      count;
   logic                               lh_ok;
   logic                               addr_chk;
   logic                               cmd_chk;
   logic [3:0]                         bit_pos;

   assign pop      = !rsp_valid_ff || !rsp_stall;
   assign count    = edge_count_ff + 1'b1;
   assign addr_chk = irnec_pkg::inverted_pair(address_shift_ff);
   assign cmd_chk  = irnec_pkg::inverted_pair(command_shift_ff);
   assign bit_pos  = ~bits_done_ff[3:0];

   always_comb begin
      receiving_in         = receiving_ff;
      edge_count_in        = edge_count_ff;
      leader_high_ok_in    = leader_high_ok_ff;
      pair_first_rising_in = pair_first_rising_ff;
      bits_done_in         = bits_done_ff;
      address_shift_in     = address_shift_ff;
      command_shift_in     = command_shift_ff;
      saved_address_in     = saved_address_ff;
      saved_command_in     = saved_command_ff;
      rsp_valid_in         = rsp_valid_ff && rsp_stall;
      rsp_in               = rsp_ff;
      lh_ok                = (edge_count_ff == irnec_pkg::COUNT_W'(1)) ?
                             pop_edge.leader_high_ok : leader_high_ok_ff;

      if (pop && pop_valid) begin
         if (!receiving_ff) begin
            if (pop_edge.rising && pop_edge.leader_low_ok) begin
               receiving_in         = 1'b1;
               edge_count_in        = irnec_pkg::COUNT_W'(1);
               leader_high_ok_in    = 1'b0;
               pair_first_rising_in = 1'b0;
               bits_done_in         = '0;
               address_shift_in     = '0;
               command_shift_in     = '0;
            end
         end else if (edge_count_ff >= irnec_pkg::COUNT_W'(irnec_pkg::EDGE_LIMIT)) begin
            // overflow: frame dropped
            receiving_in = 1'b0;
         end else begin
            edge_count_in     = count;
            leader_high_ok_in = lh_ok;
            if (!pop_edge.rising && pop_edge.frame_end) begin
               receiving_in = 1'b0;
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               priority if (count >= irnec_pkg::COUNT_W'(irnec_pkg::REPEAT_MIN_EDGES) &&
                            count <= irnec_pkg::COUNT_W'(irnec_pkg::REPEAT_MAX_EDGES) &&
                            lh_ok) begin
                  rsp_in.is_repeat   = 1'b1;
                  rsp_in.address_out = saved_address_ff;
                  rsp_in.command_out = saved_command_ff;
               end else if (count < irnec_pkg::COUNT_W'(irnec_pkg::FULL_FRAME_EDGES) ||
                            !lh_ok) begin
                  rsp_in.status = 1'b1;
               end else if (addr_chk && cmd_chk) begin
                  saved_address_in   = {8'h00, address_shift_ff[15:8]};
                  saved_command_in   = {8'h00, command_shift_ff[15:8]};
                  rsp_in.address_out = {8'h00, address_shift_ff[15:8]};
                  rsp_in.command_out = {8'h00, command_shift_ff[15:8]};
               end else if (cmd_chk) begin
                  saved_address_in   = address_shift_ff;
                  saved_command_in   = {8'h00, command_shift_ff[15:8]};
                  rsp_in.address_out = address_shift_ff;
                  rsp_in.command_out = {8'h00, command_shift_ff[15:8]};
               end else begin
                  rsp_in.status      = 1'b1;
                  rsp_in.raw_flag    = 1'b1;
                  rsp_in.address_out = address_shift_ff;
                  rsp_in.command_out = command_shift_ff;
               end
            end else if (edge_count_ff >= irnec_pkg::COUNT_W'(2)) begin
               if (!edge_count_ff[0]) begin
                  pair_first_rising_in = pop_edge.rising;
               end else if (pair_first_rising_ff && !pop_edge.rising &&
                            bits_done_ff < irnec_pkg::BITS_W'(irnec_pkg::DATA_BITS)) begin
                  if (!bits_done_ff[4]) begin
                     address_shift_in[bit_pos] = address_shift_ff[bit_pos] | pop_edge.one_bit;
                  end else begin
                     command_shift_in[bit_pos] = command_shift_ff[bit_pos] | pop_edge.one_bit;
                  end
                  bits_done_in = bits_done_ff + 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         receiving_ff         <= 1'b0;
         edge_count_ff        <= '0;
         leader_high_ok_ff    <= 1'b0;
         pair_first_rising_ff <= 1'b0;
         bits_done_ff         <= '0;
         address_shift_ff     <= '0;
         command_shift_ff     <= '0;
         saved_address_ff     <= '0;
         saved_command_ff     <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         receiving_ff         <= receiving_in;
         edge_count_ff        <= edge_count_in;
         leader_high_ok_ff    <= leader_high_ok_in;
         pair_first_rising_ff <= pair_first_rising_in;
         bits_done_ff         <= bits_done_in;
         address_shift_ff     <= address_shift_in;
         command_shift_ff     <= command_shift_in;
         saved_address_ff     <= saved_address_in;
         saved_command_ff     <= saved_command_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- bench/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the NEC infrared edge decoder.
// ----------------------------------------------------------------------------
// Timestamped line edges are sent as requests with random gaps. A local
// decoder model tracks the frame state and queues the frame result that each
// edge should close. The checker compares every result with the oldest queued
// one. The bench covers wrapped timer stamps, every threshold boundary, repeat,
// standard, extended, raw error, short and overflowed frames. It runs several
// threshold sets and long result stalls that back the decoder up.
// ----------------------------------------------------------------------------
module tb_top;
   import irnec_pkg::*;

   localparam int CYCLE_LIMIT    = 500000;
   localparam int RANDOM_EDGES   = 750;
   localparam int HOLDOFF_CYCLES = 300;
   localparam int QUIET_CYCLES   = 8;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   req_valid        = 1'b0;
   logic                   req_stall;
   logic                   req_rising_edge  = 1'b0;
   logic [TIME_W-1:0]      req_edge_time    = '0;
   logic                   rsp_valid;
   logic                   rsp_stall        = 1'b0;
   logic                   rsp_status;
   logic                   rsp_is_repeat;
   logic                   rsp_raw_flag;
   logic [TIME_W-1:0]      rsp_address_out;
   logic [TIME_W-1:0]      rsp_command_out;
   logic                   csr_write_enable = 1'b0;
   csr_index_type          csr_index        = CSR_LEADER_LOW_MIN;
   logic [TIME_W-1:0]      csr_write_data   = '0;

   ir_nec_edge_decoder_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_rising_edge  (req_rising_edge),
      .req_edge_time    (req_edge_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_is_repeat    (rsp_is_repeat),
      .rsp_raw_flag     (rsp_raw_flag),
      .rsp_address_out  (rsp_address_out),
      .rsp_command_out  (rsp_command_out),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #2 clock = ~clock;

   // decoder model state
   logic [TIME_W-1:0]  thr [6] = '{16'd8000, 16'd10000, 16'd2000, 16'd5000,
                                   16'd10000, 16'd1000};
   logic [TIME_W-1:0]  thr_next [6];
   logic               rx_active      = 1'b0;
   logic [COUNT_W-1:0] edge_cnt       = '0;
   logic [TIME_W-1:0]  prev_stamp     = '0;
   logic               lead_high_good = 1'b0;
   logic               pair_rise      = 1'b0;
   int unsigned        bit_cnt        = 0;
   logic [15:0]        addr_word      = '0;
   logic [15:0]        cmd_word       = '0;
   logic [15:0]        held_addr      = '0;
   logic [15:0]        held_cmd       = '0;
   result_type         expected_frames [$];

   logic [TIME_W-1:0]  line_time = '0;
   int unsigned        edges_sent      = 0;
   int unsigned        frames_expected = 0;
   int unsigned        mismatches      = 0;
   int unsigned        cycle_count     = 0;
   int unsigned        frame_pos       = 0;
   int unsigned        glitch_pos      = 0;
   bit                 tx_idle_on      = 1'b1;
   bit                 rx_idle_on      = 1'b1;
   int unsigned        holdoff_requests = 0;

   function automatic bit bytes_complement(input logic [15:0] w);
      return (w[15:8] ^ w[7:0]) == 8'hFF;
   endfunction

   function automatic int thr_of(input csr_index_type sel);
      return int'(thr[sel]);
   endfunction

   function automatic int pick(input int lo, input int hi);
      if (lo < 0) lo = 0;
      if (lo > 65535) lo = 65535;
      if (hi > 65535) hi = 65535;
      if (hi <= lo) return lo;
      return $urandom_range(hi, lo);
   endfunction

   function automatic logic [15:0] std_word();
      logic [7:0] b;
      b = $urandom_range(255, 0);
      return {~b, b};
   endfunction

   task automatic decode_edge(input logic rising, input logic [TIME_W-1:0] stamp);
      logic [TIME_W-1:0] span;
      int unsigned       idx;
      result_type        r;
      if (stamp >= prev_stamp) span = stamp - prev_stamp;
      else span = 16'hFFFF - prev_stamp + stamp;
      prev_stamp = stamp;
      r = '0;
      if (!rx_active) begin
         if (rising && span >= thr[CSR_LEADER_LOW_MIN] && span <= thr[CSR_LEADER_LOW_MAX]) begin
            rx_active      = 1'b1;
            edge_cnt       = 1;
            lead_high_good = 1'b0;
            pair_rise      = 1'b0;
            bit_cnt        = 0;
            addr_word      = '0;
            cmd_word       = '0;
         end
      end else if (edge_cnt >= EDGE_LIMIT) begin
         rx_active = 1'b0;
      end else begin
         idx = edge_cnt;
         edge_cnt = edge_cnt + 1'b1;
         if (idx == 1)
            lead_high_good = span >= thr[CSR_LEADER_HIGH_MIN] &&
                             span <= thr[CSR_LEADER_HIGH_MAX];
         if (!rising && span >= thr[CSR_FRAME_END_MIN]) begin
            rx_active = 1'b0;
            if (edge_cnt >= REPEAT_MIN_EDGES && edge_cnt <= REPEAT_MAX_EDGES &&
                lead_high_good) begin
               r.is_repeat   = 1'b1;
               r.address_out = held_addr;
               r.command_out = held_cmd;
            end else if (edge_cnt < FULL_FRAME_EDGES || !lead_high_good) begin
               r.status = 1'b1;
            end else if (bytes_complement(cmd_word)) begin
               held_addr = bytes_complement(addr_word) ? {8'h00, addr_word[15:8]} : addr_word;
               held_cmd  = {8'h00, cmd_word[15:8]};
               r.address_out = held_addr;
               r.command_out = held_cmd;
            end else begin
               r.status      = 1'b1;
               r.raw_flag    = 1'b1;
               r.address_out = addr_word;
               r.command_out = cmd_word;
            end
            expected_frames.push_back(r);
            frames_expected++;
         end else if (idx >= 2) begin
            if (idx % 2 == 0) begin
               pair_rise = rising;
            end else if (pair_rise && !rising && bit_cnt < DATA_BITS) begin
               if (bit_cnt < 16) addr_word[15 - bit_cnt] = span > thr[CSR_ONE_BIT_MIN];
               else cmd_word[31 - bit_cnt] = span > thr[CSR_ONE_BIT_MIN];
               bit_cnt++;
            end
         end
      end
   endtask

   // result checker
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_frames.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected frame result: st=%0d rep=%0d raw=%0d addr=%h cmd=%h",
                        rsp_status, rsp_is_repeat, rsp_raw_flag, rsp_address_out,
                        rsp_command_out);
         end else begin
            want = expected_frames.pop_front();
            if (rsp_status !== want.status || rsp_is_repeat !== want.is_repeat ||
                rsp_raw_flag !== want.raw_flag || rsp_address_out !== want.address_out ||
                rsp_command_out !== want.command_out) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("frame mismatch: exp st=%0d rep=%0d raw=%0d addr=%h cmd=%h, got st=%0d rep=%0d raw=%0d addr=%h cmd=%h",
                           want.status, want.is_repeat, want.raw_flag, want.address_out,
                           want.command_out, rsp_status, rsp_is_repeat, rsp_raw_flag,
                           rsp_address_out, rsp_command_out);
            end
         end
      end
   end

   // result side stall, with long hold-offs on request
   always @(posedge clock) begin : drive_rsp_stall
      int unsigned holdoff_seen;
      int unsigned holdoff_left;
      if (holdoff_requests != holdoff_seen) begin
         holdoff_seen = holdoff_requests;
         holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
         rsp_stall <= 1'b1;
         holdoff_left--;
      end else begin
         rsp_stall <= rx_idle_on && ($urandom_range(99, 0) < 34);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ir_nec_edge_decoder_top test failed");
         $finish;
      end
   end

   task automatic send_edge(input logic rising, input logic [TIME_W-1:0] stamp);
      while (tx_idle_on && $urandom_range(99, 0) < 34) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_rising_edge <= rising;
      req_edge_time   <= stamp;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      decode_edge(rising, stamp);
      edges_sent++;
   endtask

   task automatic send_at(input logic rising, input logic [TIME_W-1:0] stamp);
      line_time = stamp;
      send_edge(rising, stamp);
   endtask

   task automatic send_gap(input logic rising, input int gap);
      line_time = line_time + gap[15:0];
      send_edge(rising, line_time);
   endtask

   // optional direction flip at one position of a frame
   task automatic send_frame_edge(input logic rising, input int gap);
      frame_pos++;
      if (frame_pos == glitch_pos) rising = !rising;
      send_gap(rising, gap);
   endtask

   task automatic close_frame();
      while (rx_active) send_gap(1'b0, 65535);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(posedge clock);
   endtask

   task automatic load_thresholds();
      csr_index_type sel;
      close_frame();
      wait_drained();
      sel = sel.first();
      do begin
         csr_write_enable <= 1'b1;
         csr_index        <= sel;
         csr_write_data   <= thr_next[sel];
         @(posedge clock);
         thr[sel] = thr_next[sel];
         sel = sel.next();
      end while (sel != sel.first());
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_leader(input bit lead_bad);
      int lh_lo, lh_hi, fe;
      lh_lo = thr_of(CSR_LEADER_HIGH_MIN);
      lh_hi = thr_of(CSR_LEADER_HIGH_MAX);
      fe    = thr_of(CSR_FRAME_END_MIN);
      close_frame();
      send_frame_edge(1'b1, pick(thr_of(CSR_LEADER_LOW_MIN), thr_of(CSR_LEADER_LOW_MAX)));
      if (!lead_bad)
         send_frame_edge(1'b0, pick(lh_lo, (lh_hi < fe - 1) ? lh_hi : fe - 1));
      else if ($urandom_range(1, 0) && lh_lo > 0)
         send_frame_edge(1'b0, pick(lh_lo - 40, lh_lo - 1));
      else
         send_frame_edge(1'b0, pick(lh_hi + 1, lh_hi + 40));
   endtask

   task automatic send_bits(input int count, input logic [31:0] code);
      int ob, fe;
      ob = thr_of(CSR_ONE_BIT_MIN);
      fe = thr_of(CSR_FRAME_END_MIN);
      for (int i = 0; i < count; i++) begin
         send_frame_edge(1'b1, $urandom_range(700, 300));
         if (code[31 - i])
            send_frame_edge(1'b0, pick(ob + 1, (ob + 1500 < fe - 1) ? ob + 1500 : fe - 1));
         else
            send_frame_edge(1'b0, pick(ob - 800, (ob < fe - 1) ? ob : fe - 1));
      end
   endtask

   task automatic send_trailer();
      int fe;
      fe = thr_of(CSR_FRAME_END_MIN);
      if ($urandom_range(1, 0)) send_frame_edge(1'b1, $urandom_range(700, 300));
      send_frame_edge(1'b0, pick(fe, fe + 20000));
   endtask

   task automatic send_full_frame(input logic [15:0] addr, input logic [15:0] cmd,
                                  input bit lead_bad);
      send_leader(lead_bad);
      send_bits(DATA_BITS, {addr, cmd});
      send_trailer();
   endtask

   task automatic send_short_frame();
      send_leader(1'b0);
      send_bits($urandom_range(30, 0), $urandom());
      send_trailer();
   endtask

   task automatic send_repeat_frame(input int k);
      int lh_lo, lh_hi, fe;
      lh_lo = thr_of(CSR_LEADER_HIGH_MIN);
      lh_hi = thr_of(CSR_LEADER_HIGH_MAX);
      fe    = thr_of(CSR_FRAME_END_MIN);
      close_frame();
      send_frame_edge(1'b1, pick(thr_of(CSR_LEADER_LOW_MIN), thr_of(CSR_LEADER_LOW_MAX)));
      case (k)
         1: send_frame_edge(1'b0, pick((lh_lo > fe) ? lh_lo : fe, lh_hi));
         2: begin
            send_frame_edge(1'b1, pick(lh_lo, lh_hi));
            send_frame_edge(1'b0, pick(fe, fe + 20000));
         end
         default: begin
            send_frame_edge(1'b0, pick(lh_lo, (lh_hi < fe - 1) ? lh_hi : fe - 1));
            send_frame_edge(1'b1, $urandom_range(700, 300));
            send_frame_edge(1'b0, pick(fe, fe + 20000));
         end
      endcase
   endtask

   task automatic send_noise(input int count);
      csr_index_type sel;
      repeat (count) begin
         sel = csr_index_type'($urandom_range(CSR_ONE_BIT_MIN, CSR_LEADER_LOW_MIN));
         if ($urandom_range(1, 0))
            send_gap($urandom_range(1, 0), $urandom_range(65535, 0));
         else
            send_gap($urandom_range(1, 0), pick(thr_of(sel) - 1, thr_of(sel) + 1));
      end
   endtask

   task automatic send_random_frame();
      int r, k;
      frame_pos  = 0;
      glitch_pos = ($urandom_range(9, 0) == 0) ? $urandom_range(70, 1) : 0;
      r = $urandom_range(99, 0);
      k = $urandom_range(2, 0);
      if (r < 40) begin
         case (k)
            0: send_full_frame(std_word(), std_word(), 1'b0);
            1: send_full_frame($urandom_range(65535, 0), std_word(), 1'b0);
            default: send_full_frame($urandom_range(65535, 0), $urandom_range(65535, 0), 1'b0);
         endcase
      end else if (r < 70) begin
         k = $urandom_range(99, 0);
         send_repeat_frame((k < 15) ? 1 : (k < 40) ? 2 : 3);
      end else if (r < 80) begin
         send_short_frame();
      end else if (r < 85) begin
         send_full_frame(std_word(), std_word(), 1'b1);
      end else begin
         send_noise($urandom_range(6, 1));
      end
   endtask

   task automatic set_default_thresholds();
      thr_next = '{16'd8000, 16'd10000, 16'd2000, 16'd5000, 16'd10000, 16'd1000};
   endtask

   task automatic test_directed_edges();
      send_at(1'b0, 16'hFFFF);
      send_at(1'b1, 16'h0000);     // wrap formula gives zero
      send_gap(1'b1, 7999);
      send_gap(1'b1, 10001);
      send_gap(1'b1, 8000);        // leader at low bound
      send_gap(1'b0, 1999);        // leader high too short
      send_gap(1'b1, 500);
      send_gap(1'b0, 10000);
      send_gap(1'b1, 10000);       // leader at high bound
      send_gap(1'b0, 5000);
      send_gap(1'b1, 500);
      send_gap(1'b0, 10000);       // repeat before any code stored
      send_at(1'b0, 16'd60000);
      send_at(1'b1, 16'd3465);     // leader across timer wrap
      send_at(1'b0, 16'd7965);
      send_at(1'b1, 16'd8525);
      send_at(1'b0, 16'd18525);
      send_at(1'b0, 16'd50000);
      send_at(1'b1, 16'd59000);
      send_at(1'b0, 16'd63500);
      send_at(1'b1, 16'd64000);
      send_at(1'b0, 16'd8464);     // wrapped end gap reads one short
      send_gap(1'b0, 10000);
      send_gap(1'b1, 9000);
      send_gap(1'b0, 5001);        // leader high too long
      send_gap(1'b0, 10000);
      wait_drained();
   endtask

   task automatic test_frame_kinds();
      send_full_frame(16'hFF00, 16'h00FF, 1'b0);
      send_full_frame(16'h12ED, 16'h7F80, 1'b0);
      send_repeat_frame(3);
      send_full_frame(16'hFFFF, 16'h7F80, 1'b0);
      send_full_frame(16'h0000, 16'hFF00, 1'b0);
      send_repeat_frame(3);
      send_full_frame(16'h0000, 16'h0000, 1'b0);
      send_full_frame(16'hFFFF, 16'hFFFF, 1'b0);
      send_short_frame();
      send_full_frame(std_word(), std_word(), 1'b1);
      send_repeat_frame(3);
      wait_drained();
   endtask

   task automatic test_overflow();
      send_leader(1'b0);
      repeat (65) begin
         send_gap(1'b1, 500);
         send_gap(1'b0, 500);
      end
      send_gap(1'b0, 12000);
      send_repeat_frame(3);
      wait_drained();
   endtask

   task automatic test_threshold_extremes();
      thr_next = '{default: 16'h0000};
      load_thresholds();
      send_gap(1'b1, 0);
      send_gap(1'b0, 0);           // repeat of leader and closing edge
      send_gap(1'b1, 0);
      send_gap(1'b1, 0);
      send_gap(1'b0, 0);           // repeat with a rising edge between
      send_noise(30);
      thr_next = '{default: 16'hFFFF};
      load_thresholds();
      send_at(1'b0, 16'h0000);
      send_at(1'b1, 16'hFFFF);     // full scale leader
      send_noise(20);
      thr_next[CSR_LEADER_LOW_MIN]  = $urandom_range(20000, 100);
      thr_next[CSR_LEADER_LOW_MAX]  = thr_next[CSR_LEADER_LOW_MIN] + $urandom_range(4000, 0);
      thr_next[CSR_LEADER_HIGH_MIN] = $urandom_range(8000, 50);
      thr_next[CSR_LEADER_HIGH_MAX] = thr_next[CSR_LEADER_HIGH_MIN] + $urandom_range(4000, 0);
      thr_next[CSR_FRAME_END_MIN]   = thr_next[CSR_LEADER_HIGH_MAX] + $urandom_range(20000, 1);
      thr_next[CSR_ONE_BIT_MIN]     = $urandom_range(3000, 0);
      load_thresholds();
      repeat (4) send_random_frame();
      set_default_thresholds();
      load_thresholds();
      glitch_pos = 0;
   endtask

   task automatic test_random_traffic();
      int unsigned goal_edges, goal_frames;
      for (int s = 0; s < 4; s++) begin
         case (s)
            0: set_default_thresholds();
            1: thr_next = '{16'd900, 16'd1100, 16'd400, 16'd600, 16'd1500, 16'd100};
            2: thr_next = '{16'd8000, 16'd10000, 16'd2000, 16'd15000, 16'd8000, 16'd1000};
            default: begin
               thr_next[CSR_LEADER_LOW_MIN]  = $urandom_range(30000, 0);
               thr_next[CSR_LEADER_LOW_MAX]  = thr_next[CSR_LEADER_LOW_MIN] +
                                               $urandom_range(5000, 0);
               thr_next[CSR_LEADER_HIGH_MIN] = $urandom_range(10000, 0);
               thr_next[CSR_LEADER_HIGH_MAX] = thr_next[CSR_LEADER_HIGH_MIN] +
                                               $urandom_range(5000, 0);
               thr_next[CSR_FRAME_END_MIN]   = $urandom_range(40000, 1);
               thr_next[CSR_ONE_BIT_MIN]     = $urandom_range(4000, 0);
            end
         endcase
         load_thresholds();
         goal_edges  = edges_sent + RANDOM_EDGES / 4;
         goal_frames = frames_expected + 15;
         while (edges_sent < goal_edges || frames_expected < goal_frames)
            send_random_frame();
      end
      glitch_pos = 0;
      set_default_thresholds();
      load_thresholds();
   endtask

   task automatic test_backpressure();
      holdoff_requests++;
      repeat (20) send_repeat_frame(3);
      wait_drained();
      holdoff_requests++;
      repeat (4) begin
         send_full_frame(std_word(), std_word(), 1'b0);
         send_repeat_frame(3);
      end
      wait_drained();
   endtask

   task automatic test_no_idle();
      tx_idle_on = 1'b0;
      rx_idle_on = 1'b0;
      repeat (6) begin
         send_full_frame($urandom_range(65535, 0), std_word(), 1'b0);
         send_repeat_frame(3);
      end
      wait_drained();
      tx_idle_on = 1'b1;
      rx_idle_on = 1'b1;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_edges();
      test_frame_kinds();
      test_overflow();
      test_threshold_extremes();
      test_random_traffic();
      test_backpressure();
      test_no_idle();
      wait_drained();
      if (mismatches == 0 && expected_frames.size() == 0)
         $display("ir_nec_edge_decoder_top test passed");
      else
         $display("ir_nec_edge_decoder_top test failed");
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/irnec_pkg.sv
sv/irnec_csr.sv
sv/irnec_front.sv
sv/irnec_queue.sv
sv/irnec_back.sv
sv/ir_nec_edge_decoder_top.sv
bench/tb_top.sv
